@@ rtl/core/rdc_pkg.sv @@
`timescale 1ns / 1ps

package rdc_pkg;

    localparam int RADIX_W  = 6;
    localparam int CHAR_W   = 7;
    localparam int DIV_BITS = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd16;
    localparam logic [RADIX_W-1:0] DIGIT_TEN   = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO       = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA_BASE = 7'd87;

    typedef struct packed {
        logic load;
        logic step;
        logic digit_end;
        logic rd_en;
        logic load_out;
        logic out_last;
    } rdc_cmd_t;

    typedef struct packed {
        logic quo_zero;
        logic out_free;
    } rdc_status_t;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] raw);
        logic [RADIX_W-1:0] r;
        r = raw;
        if (r < RADIX_MIN) begin
            r = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            r = RADIX_MAX;
        end
        return r;
    endfunction

    // 0-9 map to '0'-'9', 10-35 to 'a'-'z'
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_TEN) begin
            c = CHAR_ZERO + {1'b0, d};
        end else begin
            c = CHAR_ALPHA_BASE + {1'b0, d};
        end
        return c;
    endfunction

endpackage

@@ rtl/core/rdc_ram.sv @@
`timescale 1ns / 1ps

module rdc_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/rdc_datapath.sv @@
`timescale 1ns / 1ps

module rdc_datapath #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [rdc_pkg::RADIX_W-1:0]    cfg_wr_data,
    input  logic [63:0]                    value,
    input  rdc_pkg::rdc_cmd_t              cmd,
    input  logic [$clog2(VALUE_WIDTH)-1:0] waddr,
    input  logic [$clog2(VALUE_WIDTH)-1:0] raddr,
    output rdc_pkg::rdc_status_t           status,
    output logic [rdc_pkg::CHAR_W-1:0]     out_char,
    output logic                           out_last,
    output logic                           out_valid,
    input  logic                           out_ready
);

    import rdc_pkg::*;

    localparam int NSTEP = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
    localparam int PW    = NSTEP * DIV_BITS;

    logic [RADIX_W-1:0] radix_reg;
    logic [PW-1:0]      quo_reg;
    logic [RADIX_W-1:0] rem_reg;
    logic [PW-1:0]      quo_step;
    logic [RADIX_W-1:0] rem_step;
    logic [RADIX_W-1:0] ram_rdata;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_wr_en) begin
            radix_reg <= clamp_radix(cfg_wr_data);
        end
    end

    // restoring division, DIV_BITS quotient bits per cycle
    always_comb begin
        logic [RADIX_W:0]   t;
        logic [PW-1:0]      q;
        logic [RADIX_W-1:0] r;
        q = quo_reg;
        r = rem_reg;
        for (int i = 0; i < DIV_BITS; i++) begin
            t = {r, q[PW-1]};
            if (t >= {1'b0, radix_reg}) begin
                t = t - {1'b0, radix_reg};
                q = {q[PW-2:0], 1'b1};
            end else begin
                q = {q[PW-2:0], 1'b0};
            end
            r = t[RADIX_W-1:0];
        end
        quo_step = q;
        rem_step = r;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            quo_reg <= PW'(value[VALUE_WIDTH-1:0]);
            rem_reg <= '0;
        end else if (cmd.step) begin
            quo_reg <= quo_step;
            rem_reg <= cmd.digit_end ? '0 : rem_step;
        end
    end

    rdc_ram #(
        .WIDTH (RADIX_W),
        .DEPTH (VALUE_WIDTH)
    ) u_digit_ram (
        .aclk  (aclk),
        .we    (cmd.digit_end),
        .waddr (waddr),
        .wdata (rem_step),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_char_reg <= digit_char(ram_rdata);
            out_last_reg <= cmd.out_last;
        end
    end

    assign status.quo_zero = (quo_step == '0);
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_char        = out_char_reg;
    assign out_last        = out_last_reg;
    assign out_valid       = out_valid_reg;

endmodule

@@ rtl/core/rdc_ctrl.sv @@
`timescale 1ns / 1ps

module rdc_ctrl #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  rdc_pkg::rdc_status_t           status,
    output rdc_pkg::rdc_cmd_t              cmd,
    output logic [$clog2(VALUE_WIDTH)-1:0] waddr,
    output logic [$clog2(VALUE_WIDTH)-1:0] raddr
);

    import rdc_pkg::*;

    localparam int NSTEP = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
    localparam int SW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;
    localparam int AW    = $clog2(VALUE_WIDTH);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_RD   = 4'b0100,
        ST_LD   = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [SW-1:0] step_reg, step_next;
    logic [AW-1:0] count_reg, count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            count_reg <= count_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        count_next = count_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    count_next = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.step = 1'b1;
                if (step_reg == SW'(NSTEP - 1)) begin
                    // remainder is the digit; store it at the current count
                    cmd.digit_end = 1'b1;
                    step_next     = '0;
                    if (status.quo_zero) begin
                        state_next = ST_RD;
                    end else begin
                        count_next = count_reg + AW'(1);
                    end
                end else begin
                    step_next = step_reg + SW'(1);
                end
            end
            ST_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_LD;
            end
            ST_LD: begin
                // hold read data until the output register frees up
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.out_last = (count_reg == '0);
                    if (count_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        count_next = count_reg - AW'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign waddr = count_reg;
    assign raddr = count_reg;

endmodule

@@ rtl/core/radix_digit_converter.sv @@
`timescale 1ns / 1ps
// The 8-bit-per-cycle divider divides the value by the radix once per digit and stores
// each remainder in the buffer RAM. The digits are then read back most significant
// first, each through the RAM's registered read into the output register, where output
// stalls hold it. A new value is accepted only after the last digit has been loaded.
// Reset: synchronous, active low; clears the controller and output valid, radix to 16.
module radix_digit_converter #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [rdc_pkg::RADIX_W-1:0] cfg_wr_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [63:0]                 s_axis_tdata,   // [63:0] value
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,   // [6:0] digit_char, [7] zero
    output logic                        m_axis_tlast
);

    import rdc_pkg::*;

    localparam int AW = $clog2(VALUE_WIDTH);

    rdc_cmd_t          ctrl_cmd;
    rdc_status_t       dp_status;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic [CHAR_W-1:0] out_char;

    rdc_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (dp_status),
        .cmd      (ctrl_cmd),
        .waddr    (waddr),
        .raddr    (raddr)
    );

    rdc_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .value       (s_axis_tdata),
        .cmd         (ctrl_cmd),
        .waddr       (waddr),
        .raddr       (raddr),
        .status      (dp_status),
        .out_char    (out_char),
        .out_last    (m_axis_tlast),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready)
    );

    assign m_axis_tdata = {1'b0, out_char};

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.load_out |-> dp_status.out_free)
        else $error("pending digit overwritten");

    a_digit_on_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.digit_end |-> (ctrl_cmd.step && !ctrl_cmd.rd_en))
        else $error("digit stored outside a divide step");

    a_read_then_load: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.rd_en |=> !ctrl_cmd.rd_en && !ctrl_cmd.step)
        else $error("read not followed by output load state");
`endif

endmodule
